>>> rtl/core/dstq_pkg.sv
// Shared types and constants for the delay sorted timer queue.
`timescale 1ns / 1ps

package dstq_pkg;

    localparam int DELAY_BITS   = 32;
    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    // Operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_POP     = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // Status codes carried by a result word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_ADV,
        S_POP,
        S_RESP
    } state_t;

    // Result handoff from sequencer to output register
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_t;

endpackage

>>> rtl/core/delay_sorted_timer_queue.sv
// Insert walks the entries with greater delay, advance walks every pending entry,
// pop reads the head, full/empty/no-op go straight to the result; one word at a time.
// Throughput is set by the one-read one-write entry store walk: about one entry per cycle.
// The next word is taken while the previous result waits in the output register.
// Reset (rst_n, async, active low) empties the queue; the store needs no clearing pass.
`timescale 1ns / 1ps

module delay_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [TAG_BITS-1:0]        task_tag,
    input  logic [DELAY_BITS-1:0]      delay,
    input  logic [DELAY_BITS-1:0]      elapsed,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [TAG_BITS-1:0]        head_tag,
    output logic [DELAY_BITS-1:0]      head_delay,
    output logic [$clog2(DEPTH+1)-1:0] occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = TAG_BITS + DELAY_BITS;

    res_t                  res;
    logic                  res_ready;
    logic [TAG_BITS-1:0]   res_tag;
    logic [DELAY_BITS-1:0] res_delay;
    logic [CNT_W-1:0]      res_count;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [TAG_BITS-1:0]   head_tag_reg;
    logic [DELAY_BITS-1:0] head_delay_reg;
    logic [CNT_W-1:0]      occupancy_reg;

    dstq_ctrl #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .task_tag  (task_tag),
        .delay     (delay),
        .elapsed   (elapsed),
        .res       (res),
        .res_ready (res_ready),
        .res_tag   (res_tag),
        .res_delay (res_delay),
        .res_count (res_count),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    dstq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register is free when empty or being taken
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            status_reg     <= res.status;
            head_tag_reg   <= res_tag;
            head_delay_reg <= res_delay;
            occupancy_reg  <= res_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign head_tag   = head_tag_reg;
    assign head_delay = head_delay_reg;
    assign occupancy  = occupancy_reg;

endmodule

>>> rtl/core/dstq_mem.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module dstq_mem
    import dstq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = TAG_BITS_DEF + DELAY_BITS
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/dstq_ctrl.sv
// Sequencer: walks the circular entry store for insert, advance and pop.
`timescale 1ns / 1ps

module dstq_ctrl
    import dstq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input word
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [TAG_BITS-1:0]          task_tag,
    input  logic [DELAY_BITS-1:0]        delay,
    input  logic [DELAY_BITS-1:0]        elapsed,
    // result handoff
    output res_t                         res,
    input  logic                         res_ready,
    output logic [TAG_BITS-1:0]          res_tag,
    output logic [DELAY_BITS-1:0]        res_delay,
    output logic [$clog2(DEPTH+1)-1:0]   res_count,
    // entry store
    output logic                         rd_en,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [TAG_BITS+DELAY_BITS-1:0] rd_data,
    output logic                         wr_en,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic [TAG_BITS+DELAY_BITS-1:0] wr_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [DELAY_BITS-1:0] dly_reg, dly_next;
    status_t               status_reg, status_next;
    logic [TAG_BITS-1:0]   rtag_reg, rtag_next;
    logic [DELAY_BITS-1:0] rdly_reg, rdly_next;

    logic [TAG_BITS-1:0]   rd_tag;
    logic [DELAY_BITS-1:0] rd_delay;
    logic [DELAY_BITS-1:0] sat_delay;
    logic [IDX_W-1:0]      last_idx;
    logic                  accept;

    // Logical position to physical address, relative to the head
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                              input logic [IDX_W-1:0] l);
        logic [IDX_W:0] s;
        s = {1'b0, hd} + {1'b0, l};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[IDX_W-1:0];
    endfunction

    assign rd_tag    = rd_data[TAG_BITS+DELAY_BITS-1:DELAY_BITS];
    assign rd_delay  = rd_data[DELAY_BITS-1:0];
    assign sat_delay = (rd_delay > dly_reg) ? rd_delay - dly_reg : '0;
    assign last_idx  = IDX_W'(count_reg - 1'b1);
    assign accept    = in_valid && (state_reg == S_IDLE);

    assign in_stall  = (state_reg != S_IDLE);
    assign res.valid = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res_tag   = rtag_reg;
    assign res_delay = rdly_reg;
    assign res_count = count_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        tag_reg    <= tag_next;
        dly_reg    <= dly_next;
        status_reg <= status_next;
        rtag_reg   <= rtag_next;
        rdly_reg   <= rdly_next;
    end

    // Next state, store accesses
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        j_next      = j_reg;
        tag_next    = tag_reg;
        dly_next    = dly_reg;
        status_next = status_reg;
        rtag_next   = rtag_reg;
        rdly_next   = rdly_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {tag_reg, dly_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    rtag_next   = '0;
                    rdly_next   = '0;
                    unique case (op_t'(opcode))
                        OP_INSERT:
                        begin
                            tag_next = task_tag;
                            dly_next = delay;
                            if (count_reg == DEPTH_C)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                j_next     = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                // start the walk at the tail
                                rd_en      = 1'b1;
                                rd_addr    = phys(head_reg, last_idx);
                                j_next     = last_idx;
                                state_next = S_INS_CMP;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            dly_next = elapsed;
                            if (count_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                j_next     = '0;
                                state_next = S_ADV;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_POP;
                            end
                        end
                        OP_NOP:
                        begin
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                // entry j arrives; shift it up or drop the new task behind it
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, j_reg + 1'b1);
                if (rd_delay > dly_reg)
                begin
                    wr_data = rd_data;
                    if (j_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, j_reg - 1'b1);
                        j_next  = j_reg - 1'b1;
                    end
                end
                else
                begin
                    wr_data    = {tag_reg, dly_reg};
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
            end

            S_INS_PUT:
            begin
                // new task goes to the head (or into an empty queue)
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, j_reg);
                wr_data    = {tag_reg, dly_reg};
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end

            S_ADV:
            begin
                // write back entry j, fetch j+1 unless j is the last
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, j_reg);
                wr_data = {rd_tag, sat_delay};
                if (j_reg == last_idx)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, j_reg + 1'b1);
                    j_next  = j_reg + 1'b1;
                end
            end

            S_POP:
            begin
                rtag_next  = rd_tag;
                rdly_next  = rd_delay;
                head_next  = phys(head_reg, IDX_W'(1));
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
